[sv/sclu_pkg.sv]
// ----------------------------------------------------------------------------
// Size class lookup package
// Shared types, codes and constants of the size class lookup unit.
// ----------------------------------------------------------------------------
package sclu_pkg;

  // Item codes.
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TABLE_STYLE = 3'd0;
  localparam logic [2:0] CFG_CLASS_COUNT = 3'd1;
  localparam logic [2:0] CFG_LARGE_THR   = 3'd2;
  localparam logic [2:0] CFG_MIDDLE_THR  = 3'd3;
  localparam logic [2:0] CFG_LARGE_ALIGN = 3'd4;

  // Size kinds.
  localparam logic [1:0] KIND_SMALL  = 2'd0;
  localparam logic [1:0] KIND_MEDIUM = 2'd1;
  localparam logic [1:0] KIND_LARGE  = 2'd2;

  // Linear class series: LINEAR_BASE + LINEAR_STEP * i.
  localparam int unsigned STEP_SHIFT  = 4;
  localparam int unsigned LINEAR_STEP = 1 << STEP_SHIFT;
  localparam int unsigned LINEAR_BASE = 24;

  // Table entries held by each cell of the search chain.
  localparam int unsigned CELL_LANES = 4;

  // Input word.
  typedef struct packed {
    logic        opcode;
    logic [31:0] request_size;
    logic [7:0]  entry_slot;
    logic [31:0] entry_bytes;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [32:0] class_bytes;
    logic [8:0]  class_number;
    logic [1:0]  size_kind;
  } out_t;

  // Table write broadcast to every cell.
  typedef struct packed {
    logic        en;
    logic [7:0]  slot;
    logic [31:0] bytes;
  } wr_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic        valid;
    logic [31:0] size;
    logic [8:0]  limit;
    logic        found;
    logic [31:0] bytes;
    logic [8:0]  number;
  } tok_t;

  // Request to the remainder unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } rem_req_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIVIDE,
    ST_DELIVER
  } state_e;

endpackage

[sv/sclu_cell.sv]
// ----------------------------------------------------------------------------
// Size class lookup search cell
// Holds a few class table entries and checks the passing search token
// against them, handing the token on to the next cell through a register.
// ----------------------------------------------------------------------------
module sclu_cell import sclu_pkg::*; #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned DEPTH    = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  wr_t  wr_i,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic [31:0]           entry_q [CELL_LANES];
  logic [CELL_LANES-1:0] lane_hit;
  tok_t                  tok_d;
  tok_t                  pay_q;
  logic                  valid_q;

  // Per-lane storage and compare.
  for (genvar j = 0; j < CELL_LANES; j++) begin : g_lane
    localparam int unsigned LaneIdx = CELL_IDX * CELL_LANES + j;
    localparam logic [8:0]  LaneNum = 9'(LaneIdx);

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (LaneIdx < DEPTH) && (wr_i.slot == 8'(LaneIdx))) begin
        entry_q[j] <= wr_i.bytes;
      end
    end

    assign lane_hit[j] = (LaneNum < tok_i.limit) && (tok_i.size <= entry_q[j]);
  end

  // The first fitting lane wins unless an earlier cell has already found one.
  always_comb begin
    tok_d = tok_i;
    for (int j = 0; j < CELL_LANES; j++) begin
      if (!tok_d.found && lane_hit[j]) begin
        tok_d.found  = 1'b1;
        tok_d.bytes  = entry_q[j];
        tok_d.number = 9'(CELL_IDX * CELL_LANES + j);
      end
    end
  end

  // Token valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  // Token payload.
  always_ff @(posedge clk_i) begin
    pay_q <= tok_d;
  end

  always_comb begin
    tok_o       = pay_q;
    tok_o.valid = valid_q;
  end

endmodule

[sv/sclu_rem.sv]
// ----------------------------------------------------------------------------
// Size class lookup remainder unit
// Restoring remainder of a 32-bit size by a 16-bit alignment, one bit per
// cycle until all 32 dividend bits have been brought in.
// ----------------------------------------------------------------------------
module sclu_rem import sclu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rem_req_t    req_i,
  output logic        done_o,
  output logic [15:0] rem_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] quo_q;
  logic [15:0] rem_q;
  logic [15:0] div_q;
  logic [16:0] trial;
  logic [15:0] rem_d;

  // One restoring step: bring in the next bit and subtract if it fits.
  always_comb begin
    trial = {rem_q, quo_q[31]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = 16'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[15:0];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[30:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  // A finished remainder is always below the divisor.
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("remainder not below divisor");

  // Completion is only ever flagged at the end of a running division.
  a_no_idle_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !req_i.start) |=> !done_q)
    else $error("done without a running division");

  // The counter only moves while busy.
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !req_i.start) |=> $stable(cnt_q))
    else $error("counter moved while idle");

endmodule

[sv/size_class_lookup_unit.sv]
// ----------------------------------------------------------------------------
// Size class lookup unit
// Maps an allocation size to a size class, class number and size kind.
// ----------------------------------------------------------------------------
// Each input word either loads one class table entry or queries a size. A
// table load is accepted while idle and gives no result. A query whose size
// equals the last cached query, and a linear-mode query, has its result set
// at acceptance. A table-mode query travels down a chain of
// ceil(min(MAX_CLASSES,256)/4) cells, four entries per cell, one cell per
// cycle, and its result is taken as the token leaves the last cell. A large
// query runs a bit-serial remainder by the large alignment. Every result
// goes through the delivery state to the output register. One query is in
// flight at a time; the next word is accepted once the result has been moved
// to the output register, even while that register still waits.
// ----------------------------------------------------------------------------
module size_class_lookup_unit import sclu_pkg::*; #(
  parameter int unsigned MAX_CLASSES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  localparam int unsigned TblDepth = (MAX_CLASSES < 256) ? MAX_CLASSES : 256;
  localparam int unsigned NumCells = (TblDepth + CELL_LANES - 1) / CELL_LANES;

  // Configuration registers.
  logic        table_style_q;
  logic [8:0]  class_count_q;
  logic [31:0] large_thr_q;
  logic [15:0] mid_thr_q;
  logic [15:0] large_align_q;

  // Control and working state.
  state_e      state_q, state_d;
  logic [31:0] last_size_q;
  logic [32:0] last_bytes_q;
  logic [8:0]  last_num_q;
  logic [31:0] work_size_q;
  logic [32:0] work_bytes_q, work_bytes_d;
  logic [8:0]  work_num_q, work_num_d;
  logic [1:0]  work_kind_q, work_kind_d;
  logic        work_load;
  logic        cache_load;
  logic        out_valid_q;
  out_t        out_data_q;
  logic        out_load;

  // Query decode.
  logic        in_acc;
  logic [31:0] size;
  logic [1:0]  kind;
  logic        is_large;
  logic        cache_hit;
  logic [32:0] lin_t;
  logic [32-STEP_SHIFT:0] lin_idx;
  logic [32:0] lin_bytes;
  logic [8:0]  lin_num;
  logic [8:0]  limit;
  logic [15:0] align_eff;
  logic [32:0] round_bytes;

  // Chain and remainder unit.
  wr_t         wr;
  tok_t        tok_head;
  tok_t        tok [NumCells+1];
  rem_req_t    rem_req;
  logic        rem_done;
  logic [15:0] rem_val;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_style_q <= 1'b0;
      class_count_q <= 9'd1;
      large_thr_q   <= 32'hFFFF_FFFF;
      mid_thr_q     <= 16'd0;
      large_align_q <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TABLE_STYLE: table_style_q <= cfg_data_i[0];
        CFG_CLASS_COUNT: class_count_q <= cfg_data_i[8:0];
        CFG_LARGE_THR:   large_thr_q   <= cfg_data_i;
        CFG_MIDDLE_THR:  mid_thr_q     <= cfg_data_i[15:0];
        CFG_LARGE_ALIGN: large_align_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign size       = in_data_i.request_size;

  // Size kind from the current thresholds.
  always_comb begin
    is_large = size > large_thr_q;
    if (is_large) begin
      kind = KIND_LARGE;
    end else if ((mid_thr_q != 16'd0) && (size >= {16'd0, mid_thr_q})) begin
      kind = KIND_MEDIUM;
    end else begin
      kind = KIND_SMALL;
    end
  end

  assign cache_hit = (size == last_size_q);

  // Linear classes: the index is the ceiling of (size - base) / step.
  always_comb begin
    lin_t   = 33'(size) - 33'(LINEAR_BASE - LINEAR_STEP + 1);
    lin_idx = lin_t[32:STEP_SHIFT];
    if (size <= 32'(LINEAR_BASE)) begin
      lin_bytes = 33'(LINEAR_BASE);
      lin_num   = 9'd0;
    end else begin
      lin_bytes = 33'(LINEAR_BASE) + {lin_idx, {STEP_SHIFT{1'b0}}};
      lin_num   = (lin_idx > (32-STEP_SHIFT+1)'(511)) ? 9'd511 : lin_idx[8:0];
    end
  end

  // Search limit is clipped to the table held in the chain.
  assign limit = (class_count_q > 9'(TblDepth)) ? 9'(TblDepth) : class_count_q;

  // Large rounding from the remainder.
  assign align_eff   = (large_align_q == 16'd0) ? 16'd1 : large_align_q;
  assign round_bytes = (rem_val == 16'd0) ? 33'(work_size_q)
                     : 33'(work_size_q) + 33'(align_eff) - 33'(rem_val);

  // Table writes broadcast to the chain.
  assign wr.en    = in_acc && (in_data_i.opcode == OP_WRITE);
  assign wr.slot  = in_data_i.entry_slot;
  assign wr.bytes = in_data_i.entry_bytes;

  // Next state, working result and unit starts.
  always_comb begin
    state_d          = state_q;
    work_load        = 1'b0;
    cache_load       = 1'b0;
    out_load         = 1'b0;
    work_bytes_d     = work_bytes_q;
    work_num_d       = work_num_q;
    work_kind_d      = work_kind_q;
    tok_head         = '0;
    tok_head.size    = size;
    tok_head.limit   = limit;
    rem_req.start    = 1'b0;
    rem_req.dividend = size;
    rem_req.divisor  = align_eff;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.opcode == OP_QUERY)) begin
          work_load   = 1'b1;
          work_kind_d = kind;
          if (cache_hit) begin
            work_bytes_d = last_bytes_q;
            work_num_d   = last_num_q;
            state_d      = ST_DELIVER;
          end else if (is_large) begin
            rem_req.start = 1'b1;
            state_d       = ST_DIVIDE;
          end else if (table_style_q) begin
            tok_head.valid = 1'b1;
            state_d        = ST_SEARCH;
          end else begin
            work_bytes_d = lin_bytes;
            work_num_d   = lin_num;
            cache_load   = 1'b1;
            state_d      = ST_DELIVER;
          end
        end
      end
      ST_SEARCH: begin
        if (tok[NumCells].valid) begin
          work_load    = 1'b1;
          cache_load   = 1'b1;
          work_bytes_d = tok[NumCells].found ? 33'(tok[NumCells].bytes) : 33'd0;
          work_num_d   = tok[NumCells].found ? tok[NumCells].number : 9'd0;
          state_d      = ST_DELIVER;
        end
      end
      ST_DIVIDE: begin
        if (rem_done) begin
          work_load    = 1'b1;
          work_bytes_d = round_bytes;
          work_num_d   = class_count_q;
          state_d      = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Search chain.
  assign tok[0] = tok_head;

  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    sclu_cell #(
      .CELL_IDX (c),
      .DEPTH    (TblDepth)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr),
      .tok_i  (tok[c]),
      .tok_o  (tok[c+1])
    );
  end

  // Remainder unit for large sizes.
  sclu_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .done_o (rem_done),
    .rem_o  (rem_val)
  );

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Last-query cache, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_size_q  <= '0;
      last_bytes_q <= '0;
      last_num_q   <= '0;
    end else if (cache_load) begin
      last_size_q  <= (state_q == ST_IDLE) ? size : work_size_q;
      last_bytes_q <= work_bytes_d;
      last_num_q   <= work_num_d;
    end
  end

  // Working result.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      work_size_q <= size;
    end
    if (work_load) begin
      work_bytes_q <= work_bytes_d;
      work_num_q   <= work_num_d;
      work_kind_q  <= work_kind_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.class_bytes  <= work_bytes_q;
      out_data_q.class_number <= work_num_q;
      out_data_q.size_kind    <= work_kind_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A token leaves the chain only while the controller waits for it.
  a_chain_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[NumCells].valid |-> (state_q == ST_SEARCH))
    else $error("search token left the chain outside a search");

  // The remainder completes only while the controller waits for it.
  a_rem_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (state_q == ST_DIVIDE))
    else $error("remainder finished outside a division");

  // An accepted query always leaves idle in the next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.opcode == OP_QUERY)) |=> (state_q != ST_IDLE))
    else $error("query accepted but controller stayed idle");

  // Nothing reaches the output register except from the delivery state.
  a_load_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q)) |-> ($past(state_q) == ST_DELIVER))
    else $error("result word loaded outside delivery");

endmodule

[tb/sclu_class_checker.sv]
// ----------------------------------------------------------------------------
// Size class lookup checker
// Watches the configuration port and both word channels of the size class
// lookup unit. It predicts the answer to every accepted query and compares
// each result word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sclu_class_checker import sclu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          hits_o,
  output int          oversize_o,
  output int          writes_o
);

  // Linear class series: the first class and the spacing between classes.
  localparam logic [63:0] SERIES_FIRST = 64'd24;
  localparam logic [63:0] SERIES_SPACING = 64'd16;

  // Register copies, as written through the configuration port.
  logic        style_q;
  logic [8:0]  count_q;
  logic [31:0] large_thr_q;
  logic [15:0] middle_thr_q;
  logic [15:0] align_q;

  // Class table and last-query cache.
  logic [31:0] class_table_q [256];
  logic [31:0] last_size_q;
  logic [32:0] last_bytes_q;
  logic [8:0]  last_number_q;

  // Answers predicted for queries whose result word has not yet arrived.
  out_t        awaited_classes_q [$];

  int fail_cnt, pending_cnt, checked_cnt, hit_cnt, oversize_cnt, write_cnt;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;
  assign checked_o    = checked_cnt;
  assign hits_o       = hit_cnt;
  assign oversize_o   = oversize_cnt;
  assign writes_o     = write_cnt;

  // Works out the answer to one query and refreshes the cache where the
  // answer is a small or medium class.
  function automatic out_t predict_class(input logic [31:0] size);
    out_t        ans;
    logic [63:0] granule;
    logic [63:0] wide;
    logic [63:0] step_idx;
    int          limit;
    bit          found;
    ans = '0;
    if (size > large_thr_q) begin
      ans.size_kind = KIND_LARGE;
    end else if (middle_thr_q != 16'd0 && size >= {16'd0, middle_thr_q}) begin
      ans.size_kind = KIND_MEDIUM;
    end else begin
      ans.size_kind = KIND_SMALL;
    end

    if (size == last_size_q) begin
      // Cache hit: the stored class wins even if registers changed since.
      ans.class_bytes  = last_bytes_q;
      ans.class_number = last_number_q;
      hit_cnt++;
    end else if (size > large_thr_q) begin
      // Oversize objects round up to the alignment; a zero granule is one.
      granule = (align_q == 16'd0) ? 64'd1 : {48'd0, align_q};
      wide = (({32'd0, size} + granule - 64'd1) / granule) * granule;
      ans.class_bytes  = wide[32:0];
      ans.class_number = count_q;
      oversize_cnt++;
    end else begin
      if (style_q) begin
        // First entry in use that is not below the size; none gives zeros.
        limit = count_q;
        if (limit > 256) begin
          limit = 256;
        end
        found = 1'b0;
        for (int i = 0; i < limit && !found; i++) begin
          if (size <= class_table_q[i]) begin
            ans.class_bytes  = {1'b0, class_table_q[i]};
            ans.class_number = i[8:0];
            found = 1'b1;
          end
        end
      end else if ({32'd0, size} <= SERIES_FIRST) begin
        ans.class_bytes  = SERIES_FIRST[32:0];
        ans.class_number = 9'd0;
      end else begin
        // Ceiling of the step count; the class number saturates at 511.
        step_idx = ({32'd0, size} - SERIES_FIRST + SERIES_SPACING - 64'd1) / SERIES_SPACING;
        wide = SERIES_FIRST + SERIES_SPACING * step_idx;
        ans.class_bytes  = wide[32:0];
        ans.class_number = (step_idx > 64'd511) ? 9'd511 : step_idx[8:0];
      end
      last_size_q   = size;
      last_bytes_q  = ans.class_bytes;
      last_number_q = ans.class_number;
    end
    return ans;
  endfunction

  // Result words are checked before the same edge's query is predicted, since
  // a word leaving at that edge always belongs to an earlier query.
  always @(posedge clk_i or negedge rst_ni) begin : watch_seq
    out_t got;
    out_t want;
    if (!rst_ni) begin
      style_q       = 1'b0;
      count_q       = 9'd1;
      large_thr_q   = 32'hFFFF_FFFF;
      middle_thr_q  = 16'd0;
      align_q       = 16'd4096;
      last_size_q   = '0;
      last_bytes_q  = '0;
      last_number_q = '0;
      foreach (class_table_q[i]) begin
        class_table_q[i] = '0;
      end
      awaited_classes_q.delete();
      fail_cnt     = 0;
      pending_cnt  = 0;
      checked_cnt  = 0;
      hit_cnt      = 0;
      oversize_cnt = 0;
      write_cnt    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (awaited_classes_q.size() == 0) begin
          $error("Result word with no query outstanding: class_bytes 0x%0h", got.class_bytes);
          fail_cnt++;
        end else begin
          want = awaited_classes_q.pop_front();
          checked_cnt++;
          if (got.class_bytes !== want.class_bytes) begin
            $error("class_bytes mismatch: expected 0x%0h, got 0x%0h",
                   want.class_bytes, got.class_bytes);
            fail_cnt++;
          end
          if (got.class_number !== want.class_number) begin
            $error("class_number mismatch: expected %0d, got %0d",
                   want.class_number, got.class_number);
            fail_cnt++;
          end
          if (got.size_kind !== want.size_kind) begin
            $error("size_kind mismatch: expected %0d, got %0d",
                   want.size_kind, got.size_kind);
            fail_cnt++;
          end
        end
      end

      // Register writes.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TABLE_STYLE: style_q      = cfg_data_i[0];
          CFG_CLASS_COUNT: count_q      = cfg_data_i[8:0];
          CFG_LARGE_THR:   large_thr_q  = cfg_data_i;
          CFG_MIDDLE_THR:  middle_thr_q = cfg_data_i[15:0];
          CFG_LARGE_ALIGN: align_q      = cfg_data_i[15:0];
          default: begin
          end
        endcase
      end

      // Accepted input words: table loads update the table, queries are
      // answered in advance.
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.opcode == OP_WRITE) begin
          class_table_q[in_data_i.entry_slot] = in_data_i.entry_bytes;
          write_cnt++;
        end else begin
          awaited_classes_q.push_back(predict_class(in_data_i.request_size));
        end
      end
      pending_cnt = awaited_classes_q.size();
    end
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Size class lookup testbench
// Drives directed and random table loads and size queries through the unit
// under a series of register settings, with random gaps on both channels.
// The checker beside the unit predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  import sclu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  // Longest table search plus margin, waited out before register writes.
  localparam int QUIET_CYCLES = 70;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_t         in_word;
  logic        out_valid;
  logic        out_ready;
  out_t        out_word;

  // Set for stretches in which neither side idles.
  bit          calm;

  int fail_count, pending, checked, hits, oversize, writes;
  int idle_cycles = 0;
  int settings_cnt;

  // Stimulus-side view of the table and registers, used to aim sizes.
  logic [31:0] table_copy [256];
  logic [31:0] prev_query;
  logic [8:0]  cur_count;
  logic [31:0] cur_large_thr;
  logic [15:0] cur_middle_thr;

  size_class_lookup_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  sclu_class_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .hits_o       (hits),
    .oversize_o   (oversize),
    .writes_o     (writes)
  );

  // Clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: ends the run once no word or register moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a handshake", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a fresh stall before every word, none in calm stretches.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Presents one word after a random gap and returns at the edge that takes
  // it. Every caller moves to the next falling edge before driving again.
  task automatic send_word(input in_t w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w.opcode == OP_WRITE) begin
      table_copy[w.entry_slot] = w.entry_bytes;
    end else begin
      prev_query = w.request_size;
    end
  endtask

  task automatic query(input logic [31:0] size);
    in_t w;
    w.opcode       = OP_QUERY;
    w.request_size = size;
    w.entry_slot   = 8'($urandom_range(0, 255));
    w.entry_bytes  = $urandom();
    send_word(w);
  endtask

  task automatic write_entry(input logic [7:0] slot, input logic [31:0] bytes);
    in_t w;
    w.opcode       = OP_WRITE;
    w.request_size = $urandom();
    w.entry_slot   = slot;
    w.entry_bytes  = bytes;
    send_word(w);
  endtask

  // Drops valid and waits until every query has been answered.
  task automatic hold_until_answered();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Writes all five registers once the unit has gone quiet.
  task automatic set_config(input bit style, input logic [8:0] count,
                            input logic [31:0] lthr, input logic [15:0] mthr,
                            input logic [15:0] align);
    hold_until_answered();
    repeat (QUIET_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TABLE_STYLE;
    cfg_data <= {31'd0, style};
    @(negedge clk);
    cfg_idx  <= CFG_CLASS_COUNT;
    cfg_data <= {23'd0, count};
    @(negedge clk);
    cfg_idx  <= CFG_LARGE_THR;
    cfg_data <= lthr;
    @(negedge clk);
    cfg_idx  <= CFG_MIDDLE_THR;
    cfg_data <= {16'd0, mthr};
    @(negedge clk);
    cfg_idx  <= CFG_LARGE_ALIGN;
    cfg_data <= {16'd0, align};
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_count      = count;
    cur_large_thr  = lthr;
    cur_middle_thr = mthr;
    settings_cnt++;
  endtask

  // Loads every slot with ascending class sizes, the last one the maximum,
  // so that no later search can touch an unloaded entry.
  task automatic load_class_table();
    logic [31:0] bytes;
    logic [8:0]  slot;
    bytes = $urandom_range(0, 16);
    for (slot = 9'd0; slot < 9'd256; slot++) begin
      write_entry(slot[7:0], (slot == 9'd255) ? 32'hFFFF_FFFF : bytes);
      bytes = bytes + $urandom_range(1, 64);
    end
  endtask

  // Sizes aimed at thresholds, table entries, the cache and the extremes.
  function automatic logic [31:0] pick_size();
    int          lim;
    logic [31:0] s;
    lim = cur_count;
    if (lim > 256) begin
      lim = 256;
    end
    if (lim == 0) begin
      lim = 1;
    end
    case ($urandom_range(0, 10))
      0:       s = $urandom();
      1:       s = prev_query;
      2:       s = $urandom_range(0, 64);
      3:       s = $urandom_range(0, 20000);
      4:       s = cur_large_thr + $urandom_range(0, 2) - 1;
      5:       s = {16'd0, cur_middle_thr} + $urandom_range(0, 2) - 1;
      6, 7:    s = table_copy[$urandom_range(0, lim - 1)] + $urandom_range(0, 2) - 1;
      8:       s = 32'hFFFF_FFFF - $urandom_range(0, 3);
      9:       s = cur_large_thr + $urandom_range(1, 100000);
      // Just past the last entry in use.
      default: s = table_copy[lim - 1] + 1;
    endcase
    return s;
  endfunction

  // One random word: mostly queries, some table loads, and now and then a
  // pause until every answer is back.
  task automatic random_item();
    logic [7:0] slot;
    if ($urandom_range(0, 39) == 0) begin
      hold_until_answered();
    end
    if ($urandom_range(0, 99) < 12) begin
      slot = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1) begin
        write_entry(slot, $urandom());
      end else begin
        write_entry(slot, table_copy[slot] + $urandom_range(0, 8) - 4);
      end
    end else begin
      query(pick_size());
    end
  endtask

  task automatic run_phase(input bit style, input logic [8:0] count,
                           input logic [31:0] lthr, input logic [15:0] mthr,
                           input logic [15:0] align, input int n, input bit quiet);
    set_config(style, count, lthr, mthr, align);
    calm = quiet;
    repeat (n) random_item();
  endtask

  // Main sequence.
  initial begin
    cfg_we         = 1'b0;
    cfg_idx        = CFG_TABLE_STYLE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_word        = '0;
    calm           = 1'b0;
    prev_query     = '0;
    cur_count      = 9'd1;
    cur_large_thr  = 32'hFFFF_FFFF;
    cur_middle_thr = 16'd0;
    settings_cnt   = 0;
    foreach (table_copy[i]) begin
      table_copy[i] = '0;
    end
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: size zero hits the cleared cache, then the linear
    // series edges, index saturation and a repeated maximum size.
    query(32'd0);
    query(32'd1);
    query(32'd24);
    query(32'd25);
    query(32'd40);
    query(32'd41);
    query(32'd8200);
    query(32'd8201);
    query(32'hFFFF_FFFF);
    query(32'hFFFF_FFFF);
    write_entry(8'd0, 32'd0);
    write_entry(8'd255, 32'hFFFF_FFFF);
    query(32'd0);

    // Zero alignment, threshold edges and a cache hit on a medium size.
    set_config(1'b0, 9'd5, 32'd1000, 16'd100, 16'd0);
    query(32'd1001);
    query(32'd1000);
    query(32'd1000);
    query(32'd99);
    query(32'd100);

    // Oversize rounding that carries into bit 32, twice, as large sizes
    // are never cached.
    set_config(1'b0, 9'd256, 32'hFFFF_FFFE, 16'hFFFF, 16'd4096);
    query(32'hFFFF_FFFF);
    query(32'hFFFF_FFFF);
    query(32'd65535);
    query(32'd65534);

    // Linear settings, one of them calm.
    run_phase(1'b0, 9'd37, 32'd5000, 16'd300, 16'd1, 20, 1'b1);
    run_phase(1'b0, 9'd256, 32'd0, 16'hFFFF, 16'hFFFF, 20, 1'b0);

    // Table settings: full table, short table, no classes, count past the
    // end of the table, single class.
    load_class_table();
    run_phase(1'b1, 9'd256, 32'hFFFF_FFFF, 16'd0, 16'd4096, 20, 1'b0);
    run_phase(1'b1, 9'd8, 32'd100000, 16'd1000, 16'd0, 20, 1'b0);
    run_phase(1'b1, 9'd0, 32'd50000, 16'd1, 16'd4096, 20, 1'b0);
    run_phase(1'b1, 9'd300, 32'h8000_0000, 16'd40000, 16'd12345, 20, 1'b0);
    run_phase(1'b1, 9'd1, 32'd20000, 16'd5000, 16'd1, 15, 1'b1);

    // Random settings.
    repeat (4) begin
      run_phase(1'($urandom_range(0, 1)), 9'($urandom_range(1, 256)),
                ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1 << 20) : $urandom(),
                16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                9, $urandom_range(0, 3) == 0);
    end

    hold_until_answered();
    repeat (QUIET_CYCLES) @(negedge clk);

    $display("Checked %0d result words (%0d cache hits, %0d oversize) and %0d table loads",
             checked, hits, oversize, writes);
    $display("over %0d register settings in linear and table modes.", settings_cnt);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
